>>> hdl/htpp_pkg.sv
// ----------------------------------------------------------------------------
// htpp_pkg
// Shared types, register indexes and constants of the header/TLV parser.
// ----------------------------------------------------------------------------
package htpp_pkg;

  localparam int HEADER_BYTES_DEF = 22;
  localparam int TEXT_KEEP_DEF    = 256;
  localparam int CHANNEL_KEEP_DEF = 32;

  localparam int          POS_W     = 17;
  localparam logic [16:0] POS_MAX   = 17'h1FFFF;
  localparam logic [7:0]  FIXED_LEN = 8'd8;
  localparam int          CFG_IDX_W = 8;

  typedef enum logic [2:0] {
    REG_EXP_VERSION  = 3'd0,
    REG_TEXT_CODE    = 3'd1,
    REG_CHANNEL_CODE = 3'd2,
    REG_TIME_CODE    = 3'd3,
    REG_REPLY_CODE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_CHANNEL = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_VER    = 3'd2,
    ST_OVERRUN    = 3'd3,
    ST_REC_TRUNC  = 3'd4,
    ST_VAL_TRUNC  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_VALUE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        segment_start;
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  ttl;
    logic [63:0] timestamp;
    logic [63:0] sender_id;
    logic [63:0] reply_id;
    logic        has_reply;
    logic [15:0] payload_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] exp_version;
    logic [7:0] text_code;
    logic [7:0] channel_code;
    logic [7:0] time_code;
    logic [7:0] reply_code;
  } cfg_t;

  // one classified step: up to a byte result and a summary
  typedef struct packed {
    logic      byte_vld;
    out_item_t byte_item;
    logic      sum_vld;
    out_item_t sum_item;
  } step_t;

endpackage

>>> hdl/header_tlv_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// header_tlv_packet_parser_unit
// Streaming header plus TLV message parser.
//
// Input channel: push one message byte with in_push while in_full is low;
// in_item.end_of_message marks the final byte of a message.
// Result channel: while out_empty is low the oldest result is on out_item;
// out_pop takes it. A byte yields a text or channel byte result, a summary
// on its final byte, both, or nothing.
// Throughput: one byte per cycle while in_full is low.
// Each result is registered into the step queue when its byte is accepted.
// A byte giving two results presents its byte result first, then its summary.
// The front and back are split by a two-step queue; when the receiver
// stalls the queue fills and in_full rises.
// Configuration: cfg_valid/cfg_ready, cfg_idx selects the register; write
// only while idle. Reset clears all message state and loads the default
// record codes and expected version.
// ----------------------------------------------------------------------------
module header_tlv_packet_parser_unit #(
  parameter int HEADER_BYTES = htpp_pkg::HEADER_BYTES_DEF,
  parameter int TEXT_KEEP    = htpp_pkg::TEXT_KEEP_DEF,
  parameter int CHANNEL_KEEP = htpp_pkg::CHANNEL_KEEP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  htpp_pkg::in_item_t                   in_item,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output htpp_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [htpp_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [7:0]                           cfg_data
);

  htpp_pkg::cfg_t  cfg_r;
  htpp_pkg::step_t step;
  logic            acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{8'd1, 8'd1, 8'd2, 8'd3, 8'd4};
    end else if (cfg_valid) begin
      case (cfg_idx)
        8'(htpp_pkg::REG_EXP_VERSION):  cfg_r.exp_version  <= cfg_data;
        8'(htpp_pkg::REG_TEXT_CODE):    cfg_r.text_code    <= cfg_data;
        8'(htpp_pkg::REG_CHANNEL_CODE): cfg_r.channel_code <= cfg_data;
        8'(htpp_pkg::REG_TIME_CODE):    cfg_r.time_code    <= cfg_data;
        8'(htpp_pkg::REG_REPLY_CODE):   cfg_r.reply_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  htpp_front #(
    .HEADER_BYTES(HEADER_BYTES), .TEXT_KEEP(TEXT_KEEP), .CHANNEL_KEEP(CHANNEL_KEEP)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .in_item(in_item), .cfg(cfg_r), .step(step)
  );

  htpp_back u_back (
    .clk(clk), .rst_n(rst_n), .step_vld(acc), .step(step), .q_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

endmodule

>>> hdl/htpp_front.sv
// ----------------------------------------------------------------------------
// htpp_front
// Header capture and record walk; emits one classified step per byte.
// ----------------------------------------------------------------------------
module htpp_front #(
  parameter int HEADER_BYTES = htpp_pkg::HEADER_BYTES_DEF,
  parameter int TEXT_KEEP    = htpp_pkg::TEXT_KEEP_DEF,
  parameter int CHANNEL_KEEP = htpp_pkg::CHANNEL_KEEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  htpp_pkg::in_item_t in_item,
  input  htpp_pkg::cfg_t     cfg,
  output htpp_pkg::step_t    step
);

  localparam logic [16:0] HB = 17'(HEADER_BYTES);
  localparam logic [8:0]  TK = 9'(TEXT_KEEP - 1);
  localparam logic [8:0]  CK = 9'(CHANNEL_KEEP - 1);

  logic [16:0] pos_r, pos_nxt;
  logic        ver_r, ver_nxt;
  logic [7:0]  type_r, type_nxt, ttl_r, ttl_nxt;
  logic [63:0] time_r, time_nxt, sender_r, sender_nxt;
  logic [15:0] len_r, len_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt, left_r, left_nxt, rlen_r, rlen_nxt;
  logic [63:0] acc_r, acc_nxt, reply_r, reply_nxt;
  logic [7:0]  kept_r, kept_nxt;
  logic        seen_r, seen_nxt;

  logic [7:0]  b;
  logic [16:0] cnt, plen;
  logic [7:0]  idx;
  logic [2:0]  st;
  logic        is_txt, is_chn, is_tim, is_rep;

  always_comb begin
    b          = in_item.data_byte;
    pos_nxt    = pos_r;   ver_nxt  = ver_r;  type_nxt = type_r; ttl_nxt = ttl_r;
    time_nxt   = time_r;  sender_nxt = sender_r; len_nxt = len_r;
    phase_nxt  = phase_r; code_nxt = code_r; left_nxt = left_r; rlen_nxt = rlen_r;
    acc_nxt    = acc_r;   kept_nxt = kept_r; reply_nxt = reply_r; seen_nxt = seen_r;
    step       = '0;
    idx        = rlen_r - left_r;
    is_txt     = (code_r == cfg.text_code);
    is_chn     = !is_txt && (code_r == cfg.channel_code);
    is_tim     = !is_txt && !is_chn && (code_r == cfg.time_code);
    is_rep     = !is_txt && !is_chn && !is_tim && (code_r == cfg.reply_code);
    plen       = pos_r - HB;
    if (pos_r < HB) begin
      if (pos_r == 17'd0) ver_nxt = (b == cfg.exp_version);
      else if (pos_r == 17'd1) type_nxt = b;
      else if (pos_r == 17'd2) ttl_nxt = b;
      else if (pos_r <= 17'd10) time_nxt = {time_r[55:0], b};
      else if (pos_r == 17'd12) len_nxt = {b, 8'd0};
      else if (pos_r == 17'd13) len_nxt = {len_r[15:8], b};
      else if (pos_r >= 17'd14 && pos_r <= 17'd21)
        sender_nxt = sender_r | ({56'd0, b} << {pos_r[2:0] - 3'd6, 3'd0});
    end else if (ver_r && plen < {1'b0, len_r}) begin
      unique case (phase_r)
        htpp_pkg::PH_TYPE: begin
          code_nxt = b; phase_nxt = htpp_pkg::PH_LENGTH;
        end
        htpp_pkg::PH_LENGTH: begin
          rlen_nxt = b; left_nxt = b; kept_nxt = '0; acc_nxt = '0;
          phase_nxt = (b == 8'd0) ? htpp_pkg::PH_TYPE : htpp_pkg::PH_VALUE;
        end
        default: begin
          if ((is_txt && {1'b0, kept_r} < TK) || (is_chn && {1'b0, kept_r} < CK)) begin
            step.byte_vld = 1'b1;
            step.byte_item.kind = is_txt ? htpp_pkg::KIND_TEXT : htpp_pkg::KIND_CHANNEL;
            step.byte_item.out_byte = b;
            step.byte_item.segment_start = (idx == 8'd0);
            kept_nxt = kept_r + 8'd1;
          end
          if (is_tim) acc_nxt = {acc_r[55:0], b};
          if (is_rep && idx < htpp_pkg::FIXED_LEN)
            acc_nxt = acc_r | ({56'd0, b} << {idx[2:0], 3'd0});
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            if (rlen_r == htpp_pkg::FIXED_LEN && is_tim) time_nxt = acc_nxt;
            if (rlen_r == htpp_pkg::FIXED_LEN && is_rep) begin
              reply_nxt = acc_nxt; seen_nxt = 1'b1;
            end
            phase_nxt = htpp_pkg::PH_TYPE;
          end
        end
      endcase
    end
    if (pos_r != htpp_pkg::POS_MAX) pos_nxt = pos_r + 17'd1;
    cnt = pos_nxt;
    if (cnt < HB) st = htpp_pkg::ST_SHORT;
    else if (!ver_nxt) st = htpp_pkg::ST_BAD_VER;
    else if ({1'b0, cnt} < {1'b0, HB} + {2'b0, len_nxt}) st = htpp_pkg::ST_OVERRUN;
    else if (phase_nxt == htpp_pkg::PH_LENGTH) st = htpp_pkg::ST_REC_TRUNC;
    else if (phase_nxt == htpp_pkg::PH_VALUE) st = htpp_pkg::ST_VAL_TRUNC;
    else st = htpp_pkg::ST_OK;
    step.sum_vld = in_item.end_of_message;
    step.sum_item.kind = htpp_pkg::KIND_SUMMARY;
    step.sum_item.status = st;
    step.sum_item.msg_type = type_nxt;
    step.sum_item.ttl = ttl_nxt;
    step.sum_item.timestamp = time_nxt;
    step.sum_item.sender_id = sender_nxt;
    step.sum_item.reply_id = reply_nxt;
    step.sum_item.has_reply = seen_nxt;
    step.sum_item.payload_length = len_nxt;
    step.sum_item.last = 1'b1;
    step.byte_item.last = !in_item.end_of_message;
    if (in_item.end_of_message) begin
      pos_nxt = '0; ver_nxt = 1'b0; type_nxt = '0; ttl_nxt = '0; time_nxt = '0;
      sender_nxt = '0; len_nxt = '0; phase_nxt = htpp_pkg::PH_TYPE; code_nxt = '0;
      left_nxt = '0; rlen_nxt = '0; acc_nxt = '0; kept_nxt = '0; reply_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; ver_r <= 1'b0; type_r <= '0; ttl_r <= '0; time_r <= '0;
      sender_r <= '0; len_r <= '0; phase_r <= htpp_pkg::PH_TYPE; code_r <= '0;
      left_r <= '0; rlen_r <= '0; acc_r <= '0; kept_r <= '0; reply_r <= '0;
      seen_r <= 1'b0;
    end else if (in_vld) begin
      pos_r <= pos_nxt; ver_r <= ver_nxt; type_r <= type_nxt; ttl_r <= ttl_nxt;
      time_r <= time_nxt; sender_r <= sender_nxt; len_r <= len_nxt;
      phase_r <= phase_nxt; code_r <= code_nxt; left_r <= left_nxt;
      rlen_r <= rlen_nxt; acc_r <= acc_nxt; kept_r <= kept_nxt;
      reply_r <= reply_nxt; seen_r <= seen_nxt;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("record phase out of range");
  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == htpp_pkg::PH_VALUE |-> left_r != 8'd0) else $error("empty value phase");
  a_eom_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_item.end_of_message |=> pos_r == 17'd0) else $error("no clear");

endmodule

>>> hdl/htpp_back.sv
// ----------------------------------------------------------------------------
// htpp_back
// Step queue and result sequencing; delivers byte and summary results.
// ----------------------------------------------------------------------------
module htpp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_vld,
  input  htpp_pkg::step_t     step,
  output logic                q_full,
  output logic                out_empty,
  input  logic                out_pop,
  output htpp_pkg::out_item_t out_item
);

  localparam int DEPTH = 2;

  htpp_pkg::step_t q_r [DEPTH];
  logic       wp_r, rp_r, sel_r;
  logic [1:0] cnt_r;
  logic       push, pop_step, has_b, has_s;
  htpp_pkg::step_t head;

  assign head      = q_r[rp_r];
  assign has_b     = head.byte_vld && !sel_r;
  assign has_s     = head.sum_vld;
  assign out_empty = (cnt_r == 2'd0);
  assign out_item  = has_b ? head.byte_item : head.sum_item;
  assign q_full    = (cnt_r == 2'(DEPTH));
  assign push      = step_vld && (step.byte_vld || step.sum_vld);
  assign pop_step  = out_pop && !out_empty && !(has_b && has_s);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0; sel_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop_step) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop_step);
      if (pop_step) sel_r <= 1'b0;
      else if (out_pop && !out_empty) sel_r <= 1'b1;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(DEPTH)) else $error("queue overflow");
  a_sel_sum: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !out_empty && head.sum_vld) else $error("split step lost summary");
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind == htpp_pkg::KIND_SUMMARY |-> out_item.last)
    else $error("summary not last");

endmodule

>>> test/header_tlv_packet_parser_unit_test.sv
// ----------------------------------------------------------------------------
// header_tlv_packet_parser_unit_test
// Self-checking bench for the header/TLV parser: directed and random
// messages are pushed byte by byte with random gaps, every result is
// compared field by field against an in-bench parser model, and the record
// codes and expected version are changed between phases.
// ----------------------------------------------------------------------------
module header_tlv_packet_parser_unit_test;
  import htpp_pkg::*;

  localparam int HDR = 22;
  localparam int TKEEP = 256;
  localparam int CKEEP = 32;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;

  always #1 clk = ~clk;

  header_tlv_packet_parser_unit dut (.*);

  // model state
  cfg_t regs;
  logic [16:0] pos;
  logic ver_ok;
  logic [7:0] m_type, m_ttl;
  logic [63:0] m_time, m_sender, m_reply;
  logic [15:0] m_len;
  phase_t phase;
  logic [7:0] rec_code, rec_left, rec_len, kept;
  logic [63:0] accum;
  logic reply_seen;

  in_item_t pending_bytes[$];
  out_item_t expected_results[$];
  int errors = 0;
  int checked = 0;
  int messages = 0;
  bit hold_sender = 0;
  int rx_hold = 0;
  int idle_cycles = 0;

  task automatic clear_msg();
    pos = '0; ver_ok = 0; m_type = '0; m_ttl = '0; m_time = '0; m_sender = '0;
    m_len = '0; phase = PH_TYPE; rec_code = '0; rec_left = '0; rec_len = '0;
    accum = '0; kept = '0; m_reply = '0; reply_seen = 0;
  endtask

  task automatic push_text(kind_t k, logic [7:0] b, logic seg);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.out_byte = b;
    r.segment_start = seg;
    expected_results.push_back(r);
  endtask

  task automatic parse_byte(in_item_t it);
    logic [7:0] b;
    logic [7:0] idx;
    int n0;
    out_item_t r;
    b = it.data_byte;
    n0 = expected_results.size();
    if (pos < HDR) begin
      if (pos == 0) ver_ok = (b == regs.exp_version);
      else if (pos == 1) m_type = b;
      else if (pos == 2) m_ttl = b;
      else if (pos <= 10) m_time = {m_time[55:0], b};
      else if (pos == 12) m_len = {b, 8'h00};
      else if (pos == 13) m_len[7:0] = b;
      else if (pos >= 14 && pos <= 21) m_sender |= 64'(b) << (8 * (pos - 14));
    end else if (ver_ok && (pos - HDR) < m_len) begin
      if (phase == PH_TYPE) begin
        rec_code = b;
        phase = PH_LENGTH;
      end else if (phase == PH_LENGTH) begin
        rec_len = b; rec_left = b; kept = '0; accum = '0;
        phase = (b == 0) ? PH_TYPE : PH_VALUE;
      end else begin
        idx = rec_len - rec_left;
        if (rec_code == regs.text_code) begin
          if (kept < TKEEP - 1) begin
            push_text(KIND_TEXT, b, idx == 0);
            kept++;
          end
        end else if (rec_code == regs.channel_code) begin
          if (kept < CKEEP - 1) begin
            push_text(KIND_CHANNEL, b, idx == 0);
            kept++;
          end
        end else if (rec_code == regs.time_code) begin
          accum = {accum[55:0], b};
        end else if (rec_code == regs.reply_code) begin
          if (idx < 8) accum |= 64'(b) << (8 * idx);
        end
        rec_left--;
        if (rec_left == 0) begin
          if (rec_len == FIXED_LEN && rec_code != regs.text_code &&
              rec_code != regs.channel_code) begin
            if (rec_code == regs.time_code) m_time = accum;
            else if (rec_code == regs.reply_code) begin
              m_reply = accum;
              reply_seen = 1;
            end
          end
          phase = PH_TYPE;
        end
      end
    end
    if (pos != POS_MAX) pos = pos + 1;
    if (it.end_of_message) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      if (pos < HDR) r.status = ST_SHORT;
      else if (!ver_ok) r.status = ST_BAD_VER;
      else if (pos < HDR + m_len) r.status = ST_OVERRUN;
      else if (phase == PH_LENGTH) r.status = ST_REC_TRUNC;
      else if (phase == PH_VALUE) r.status = ST_VAL_TRUNC;
      else r.status = ST_OK;
      r.msg_type = m_type; r.ttl = m_ttl; r.timestamp = m_time;
      r.sender_id = m_sender; r.reply_id = m_reply; r.has_reply = reply_seen;
      r.payload_length = m_len;
      expected_results.push_back(r);
      messages++;
      clear_msg();
    end
    if (expected_results.size() > n0) expected_results[$].last = 1'b1;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
  endtask

  // message builder
  logic [7:0] msg[$];

  task automatic add_header(logic [7:0] ver, logic [15:0] len);
    msg.push_back(ver);
    for (int i = 1; i < HDR; i++) msg.push_back(8'($urandom));
    msg[12] = len[15:8];
    msg[13] = len[7:0];
  endtask

  task automatic add_record(logic [7:0] code, int n);
    msg.push_back(code);
    msg.push_back(8'(n));
    for (int i = 0; i < n; i++) msg.push_back(8'($urandom));
  endtask

  // fix payload length to what follows the header
  task automatic seal_length();
    logic [15:0] l;
    l = 16'(msg.size() - HDR);
    msg[12] = l[15:8];
    msg[13] = l[7:0];
  endtask

  task automatic queue_msg();
    in_item_t it;
    foreach (msg[i]) begin
      it.data_byte = msg[i];
      it.end_of_message = (i == msg.size() - 1);
      pending_bytes.push_back(it);
    end
    msg.delete();
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0: return regs.text_code;
      1: return regs.channel_code;
      2: return regs.time_code;
      3: return regs.reply_code;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_msg();
    int kind_sel, nrec, l;
    kind_sel = $urandom_range(0, 19);
    if (kind_sel == 0) begin
      l = $urandom_range(1, 40);
      for (int i = 0; i < l; i++) msg.push_back(8'($urandom));
    end else begin
      add_header((kind_sel == 1) ? 8'($urandom) : regs.exp_version, 0);
      nrec = $urandom_range(0, 4);
      for (int i = 0; i < nrec; i++) begin
        l = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 12);
        if ($urandom_range(0, 40) == 0) l = $urandom_range(30, 255);
        add_record(pick_code(), l);
      end
      seal_length();
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 5)) void'(msg.pop_back());
        1: repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
        2: begin
          l = msg.size() - HDR + $urandom_range(0, 3);
          msg[12] = 8'(l >> 8);
          msg[13] = 8'(l);
        end
        default: ;
      endcase
      if (msg.size() == 0) msg.push_back(8'($urandom));
    end
    queue_msg();
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n || hold_sender) begin
      in_push <= 1'b0;
    end else if (in_push && in_full) begin
    end else if (pending_bytes.size() > 0 && $urandom_range(0, 3) != 0) begin
      in_push <= 1'b1;
      in_item <= pending_bytes[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      parse_byte(in_item);
      void'(pending_bytes.pop_front());
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_pop <= 1'b0;
    end else begin
      case ($urandom_range(0, 29))
        0: begin rx_hold <= $urandom_range(20, 60); out_pop <= 1'b0; end
        1, 2, 3: begin rx_hold <= $urandom_range(0, 3); out_pop <= 1'b0; end
        default: out_pop <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        report("unexpected kind", 64'(out_item.kind), 64'd0);
      end else begin
        w = expected_results.pop_front();
        if (out_item.kind != w.kind) report("kind", out_item.kind, w.kind);
        if (out_item.out_byte != w.out_byte) report("out_byte", out_item.out_byte, w.out_byte);
        if (out_item.segment_start != w.segment_start)
          report("segment_start", out_item.segment_start, w.segment_start);
        if (out_item.status != w.status) report("status", out_item.status, w.status);
        if (out_item.msg_type != w.msg_type) report("msg_type", out_item.msg_type, w.msg_type);
        if (out_item.ttl != w.ttl) report("ttl", out_item.ttl, w.ttl);
        if (out_item.timestamp != w.timestamp)
          report("timestamp", out_item.timestamp, w.timestamp);
        if (out_item.sender_id != w.sender_id)
          report("sender_id", out_item.sender_id, w.sender_id);
        if (out_item.reply_id != w.reply_id) report("reply_id", out_item.reply_id, w.reply_id);
        if (out_item.has_reply != w.has_reply)
          report("has_reply", out_item.has_reply, w.has_reply);
        if (out_item.payload_length != w.payload_length)
          report("payload_length", out_item.payload_length, w.payload_length);
        if (out_item.last != w.last) report("last", out_item.last, w.last);
        checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) ||
        !rst_n || (pending_bytes.size() == 0 && expected_results.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(cfg_reg_t r, logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_idx <= CFG_IDX_W'(r);
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_EXP_VERSION: regs.exp_version = v;
      REG_TEXT_CODE: regs.text_code = v;
      REG_CHANNEL_CODE: regs.channel_code = v;
      REG_TIME_CODE: regs.time_code = v;
      default: regs.reply_code = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_codes(logic [7:0] v, logic [7:0] t, logic [7:0] c,
                           logic [7:0] ts, logic [7:0] rp);
    drain();
    write_reg(REG_EXP_VERSION, v);
    write_reg(REG_TEXT_CODE, t);
    write_reg(REG_CHANNEL_CODE, c);
    write_reg(REG_TIME_CODE, ts);
    write_reg(REG_REPLY_CODE, rp);
  endtask

  initial begin
    regs = '{8'd1, 8'd1, 8'd2, 8'd3, 8'd4};
    clear_msg();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full-featured message, then each failure mode
    add_header(8'd1, 0);
    msg[3] = 8'hFF; msg[14] = 8'h00; msg[21] = 8'hFF;
    add_record(8'd1, 3);
    add_record(8'd2, 40);
    add_record(8'd3, 8);
    add_record(8'd4, 8);
    add_record(8'd1, 0);
    add_record(8'd3, 5);
    add_record(8'd9, 2);
    seal_length();
    msg.push_back(8'hAA);
    queue_msg();
    add_header(8'd1, 0); add_record(8'd1, 255); seal_length(); queue_msg();
    msg.push_back(8'd1); queue_msg();
    add_header(8'd7, 4); msg.push_back(8'd1); msg.push_back(8'd1); queue_msg();
    add_header(8'd1, 10); msg.push_back(8'd1); queue_msg();
    add_header(8'd1, 1); msg.push_back(8'd1); queue_msg();
    add_header(8'd1, 3); msg.push_back(8'd2); msg.push_back(8'd5); msg.push_back(8'h41);
    queue_msg();
    add_header(8'd1, 0); msg[12] = 8'hFF; msg[13] = 8'hFF; queue_msg();
    drain();

    // long receiver stall while the sender keeps pushing
    rx_hold = 300;
    for (int i = 0; i < 4; i++) random_msg();
    drain();

    // equal codes, extremes
    set_codes(8'd0, 8'd5, 8'd5, 8'd5, 8'd5);
    for (int i = 0; i < 2; i++) random_msg();
    set_codes(8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F);
    for (int i = 0; i < 2; i++) random_msg();
    set_codes(8'd1, 8'd1, 8'd2, 8'd3, 8'd4);

    for (int ph = 0; ph < 4; ph++) begin
      random_msg();
      // sender waits for every expected result
      while (pending_bytes.size() > 0) @(posedge clk);
      hold_sender = 1;
      while (expected_results.size() > 0) @(posedge clk);
      hold_sender = 0;
      random_msg();
      set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    drain();

    $display("covered %0d messages and %0d results over several register settings",
             messages, checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
